### hw/rtl/infix_expression_evaluator_defines.svh
// Assertion macros shared by the infix expression evaluator checkers.
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IEE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("infix evaluator check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IEE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("infix evaluator check failed");

`endif

### hw/rtl/iee_pkg.sv
// Types, constants and helpers of the infix expression evaluator.
package iee_pkg;

    // Stack geometry and arithmetic width
    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Port field widths
    localparam int KIND_W     = 3;
    localparam int IO_VALUE_W = 32;
    localparam int STATUS_W   = 2;

    // Token kinds on the request channel
    typedef enum logic [KIND_W-1:0] {
        KIND_OPERAND = 3'd0,
        KIND_PLUS    = 3'd1,
        KIND_MINUS   = 3'd2,
        KIND_TIMES   = 3'd3,
        KIND_OPEN    = 3'd4,
        KIND_CLOSE   = 3'd5,
        KIND_END     = 3'd6
    } kind_t;

    // Operator stack entries
    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_PLUS  = 2'd1,
        OP_MINUS = 2'd2,
        OP_TIMES = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    // Binding strength: times above plus and minus, open lowest
    function automatic logic [1:0] prec_of(op_t op);
        logic [1:0] p;
        case (op)
            OP_TIMES: p = 2'd2;
            OP_OPEN:  p = 2'd0;
            default:  p = 2'd1;
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/iee_if.sv
// Valid/ready channel interfaces for requests (tokens) and responses (results).
interface iee_req_if;
    logic                                valid;
    logic                                ready;
    logic [iee_pkg::KIND_W-1:0]          req_type;
    logic signed [iee_pkg::IO_VALUE_W-1:0] operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

interface iee_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [iee_pkg::IO_VALUE_W-1:0] result_value;
    logic [iee_pkg::STATUS_W-1:0]          status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

### hw/rtl/infix_expression_evaluator.sv
// Top level of the two-stack infix expression evaluator.
//
// Usage: tokens arrive on req (valid/ready), one per transfer: operands with a
// signed 32-bit value, plus, minus, times, open, close and an end mark.  One
// result per end mark leaves on rsp (valid/ready): the wrapped value and a
// status (ok, stack overflow or malformed; value is 0 on error).
// Timing: req.ready is high only while the sequencer is idle, so a new token is
// taken only once the last one is done.  An operator, close or end mark reduces
// stacked operators one at a time, so nesting depth sets the rate; an error cuts
// the reductions short.  Each reduction goes through the one arithmetic unit and
// the single read port of the operand stack RAM (right operand, then left
// operand, then write-back).
// The result sits in an output register; while the receiver stalls, further
// tokens are still taken until the next end mark needs that register, and that
// end mark then waits in its last cycle until the register is free.
// Reset: both stack counts and the error status clear at once; stack RAM
// contents are not cleared since only entries below the counts are read.
module infix_expression_evaluator (
    input  logic      clk,
    input  logic      rst_n,
    iee_req_if.sink   req,
    iee_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP_RD,
        S_OP_CHK,
        S_RD_RHS,
        S_RD_LHS,
        S_EXEC,
        S_FIN_RD,
        S_FIN_OUT
    } state_t;

    localparam int AW = iee_pkg::ADDR_W;
    localparam int CW = iee_pkg::CNT_W;
    localparam int VW = iee_pkg::VALUE_WIDTH;
    localparam int OW = iee_pkg::IO_VALUE_W;

    state_t                       state_reg, state_next;
    logic [iee_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [CW-1:0]                nd_cnt_reg, nd_cnt_next;
    logic [CW-1:0]                op_cnt_reg, op_cnt_next;
    iee_pkg::status_t             err_reg, err_next;
    iee_pkg::op_t                 top_op_reg, top_op_next;
    logic [VW-1:0]                rhs_reg, rhs_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic signed [OW-1:0]         rsp_value_reg, rsp_value_next;
    iee_pkg::status_t             rsp_status_reg, rsp_status_next;

    logic [CW-1:0]                nd_cnt_m1, nd_cnt_m2, op_cnt_m1;
    logic                         nd_full, op_full;
    logic                         reduce_req;
    iee_pkg::op_t                 op_top, kind_op;
    iee_pkg::status_t             flag_code;
    logic                         flag_req;

    logic                         nd_we;
    logic [AW-1:0]                nd_waddr, nd_raddr;
    logic [VW-1:0]                nd_wdata, nd_rdata;
    logic                         op_we;
    logic [AW-1:0]                op_waddr;
    logic [1:0]                   op_wdata, op_rdata;
    logic [VW-1:0]                alu_y;

    // Stack storage and the shared arithmetic unit
    iee_ram #(.WIDTH(VW), .DEPTH(iee_pkg::STACK_DEPTH)) u_nd_ram (
        .clk   (clk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    iee_ram #(.WIDTH(2), .DEPTH(iee_pkg::STACK_DEPTH)) u_op_ram (
        .clk   (clk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata (op_wdata),
        .raddr (op_cnt_m1[AW-1:0]),
        .rdata (op_rdata)
    );

    iee_alu u_alu (
        .op  (top_op_reg),
        .lhs (nd_rdata),
        .rhs (rhs_reg),
        .y   (alu_y)
    );

    // Derive stack pointers and full flags
    assign nd_cnt_m1 = nd_cnt_reg - CW'(1);
    assign nd_cnt_m2 = nd_cnt_reg - CW'(2);
    assign op_cnt_m1 = op_cnt_reg - CW'(1);
    assign nd_full   = (nd_cnt_reg >= CW'(iee_pkg::STACK_DEPTH));
    assign op_full   = (op_cnt_reg >= CW'(iee_pkg::STACK_DEPTH));
    assign op_top    = iee_pkg::op_t'(op_rdata);
    assign kind_op   = iee_pkg::op_t'(kind_reg[1:0]);

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.status       = rsp_status_reg;

    // Sequence token handling, reductions and result delivery
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        nd_cnt_next     = nd_cnt_reg;
        op_cnt_next     = op_cnt_reg;
        top_op_next     = top_op_reg;
        rhs_next        = rhs_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        flag_req        = 1'b0;
        flag_code       = iee_pkg::ST_MALFORMED;
        reduce_req      = 1'b0;
        nd_we           = 1'b0;
        nd_waddr        = nd_cnt_reg[AW-1:0];
        nd_wdata        = alu_y;
        nd_raddr        = nd_cnt_m1[AW-1:0];
        op_we           = 1'b0;
        op_waddr        = op_cnt_reg[AW-1:0];
        op_wdata        = kind_op;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next = req.req_type;
                    if (req.req_type == iee_pkg::KIND_END)
                    begin
                        state_next = S_OP_RD;
                    end
                    else if (err_reg == iee_pkg::ST_OK)
                    begin
                        case (req.req_type)
                            iee_pkg::KIND_OPERAND:
                            begin
                                if (nd_full)
                                begin
                                    flag_req  = 1'b1;
                                    flag_code = iee_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    nd_we       = 1'b1;
                                    nd_wdata    = VW'(req.operand_value);
                                    nd_cnt_next = nd_cnt_reg + CW'(1);
                                end
                            end
                            iee_pkg::KIND_OPEN:
                            begin
                                if (op_full)
                                begin
                                    flag_req  = 1'b1;
                                    flag_code = iee_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    op_we       = 1'b1;
                                    op_wdata    = iee_pkg::OP_OPEN;
                                    op_cnt_next = op_cnt_reg + CW'(1);
                                end
                            end
                            iee_pkg::KIND_PLUS, iee_pkg::KIND_MINUS,
                            iee_pkg::KIND_TIMES, iee_pkg::KIND_CLOSE:
                            begin
                                state_next = S_OP_RD;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_OP_RD:
            begin
                if (err_reg != iee_pkg::ST_OK)
                begin
                    state_next = (kind_reg == iee_pkg::KIND_END) ? S_FIN_RD : S_IDLE;
                end
                else if (op_cnt_reg == '0)
                begin
                    case (kind_reg)
                        iee_pkg::KIND_PLUS, iee_pkg::KIND_MINUS, iee_pkg::KIND_TIMES:
                        begin
                            op_we       = 1'b1;
                            op_cnt_next = op_cnt_reg + CW'(1);
                            state_next  = S_IDLE;
                        end
                        iee_pkg::KIND_CLOSE:
                        begin
                            flag_req   = 1'b1;
                            state_next = S_IDLE;
                        end
                        iee_pkg::KIND_END:
                        begin
                            state_next = S_FIN_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_OP_CHK;
                end
            end

            S_OP_CHK:
            begin
                case (kind_reg)
                    iee_pkg::KIND_PLUS, iee_pkg::KIND_MINUS, iee_pkg::KIND_TIMES:
                    begin
                        if (op_top != iee_pkg::OP_OPEN &&
                            iee_pkg::prec_of(op_top) >= iee_pkg::prec_of(kind_op))
                        begin
                            reduce_req = 1'b1;
                        end
                        else
                        begin
                            if (op_full)
                            begin
                                flag_req  = 1'b1;
                                flag_code = iee_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                op_we       = 1'b1;
                                op_cnt_next = op_cnt_reg + CW'(1);
                            end
                            state_next = S_IDLE;
                        end
                    end
                    iee_pkg::KIND_CLOSE:
                    begin
                        if (op_top == iee_pkg::OP_OPEN)
                        begin
                            op_cnt_next = op_cnt_m1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            reduce_req = 1'b1;
                        end
                    end
                    iee_pkg::KIND_END:
                    begin
                        if (op_top == iee_pkg::OP_OPEN)
                        begin
                            flag_req   = 1'b1;
                            state_next = S_FIN_RD;
                        end
                        else
                        begin
                            reduce_req = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase

                // Pop the top operator; reduce only with two operands present
                if (reduce_req)
                begin
                    op_cnt_next = op_cnt_m1;
                    top_op_next = op_top;
                    if (nd_cnt_reg < CW'(2))
                    begin
                        flag_req   = 1'b1;
                        state_next = S_OP_RD;
                    end
                    else
                    begin
                        state_next = S_RD_RHS;
                    end
                end
            end

            S_RD_RHS:
            begin
                nd_raddr   = nd_cnt_m1[AW-1:0];
                state_next = S_RD_LHS;
            end

            S_RD_LHS:
            begin
                nd_raddr   = nd_cnt_m2[AW-1:0];
                rhs_next   = nd_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                nd_we       = 1'b1;
                nd_waddr    = nd_cnt_m2[AW-1:0];
                nd_wdata    = alu_y;
                nd_cnt_next = nd_cnt_m1;
                state_next  = S_OP_RD;
            end

            S_FIN_RD:
            begin
                nd_raddr = '0;
                if (nd_cnt_reg != CW'(1))
                begin
                    flag_req = 1'b1;
                end
                state_next = S_FIN_OUT;
            end

            S_FIN_OUT:
            begin
                nd_raddr = '0;
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = err_reg;
                    rsp_value_next  = (err_reg == iee_pkg::ST_OK) ?
                                      OW'($signed(nd_rdata)) : '0;
                    nd_cnt_next     = '0;
                    op_cnt_next     = '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Keep only the first error of an expression; clear it after the result
    always_comb
    begin
        err_next = err_reg;
        if (state_reg == S_FIN_OUT && (!rsp_valid_reg || rsp.ready))
        begin
            err_next = iee_pkg::ST_OK;
        end
        else if (flag_req && err_reg == iee_pkg::ST_OK)
        begin
            err_next = flag_code;
        end
    end

    // Hold state, counters and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            nd_cnt_reg     <= '0;
            op_cnt_reg     <= '0;
            err_reg        <= iee_pkg::ST_OK;
            top_op_reg     <= iee_pkg::OP_OPEN;
            rhs_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_value_reg  <= '0;
            rsp_status_reg <= iee_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            nd_cnt_reg     <= nd_cnt_next;
            op_cnt_reg     <= op_cnt_next;
            err_reg        <= err_next;
            top_op_reg     <= top_op_next;
            rhs_reg        <= rhs_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_value_reg  <= rsp_value_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

endmodule

### hw/rtl/iee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/iee_alu.sv
// Shared arithmetic unit: applies one stacked operator to two operands.
module iee_alu (
    input  iee_pkg::op_t                    op,
    input  logic [iee_pkg::VALUE_WIDTH-1:0] lhs,
    input  logic [iee_pkg::VALUE_WIDTH-1:0] rhs,
    output logic [iee_pkg::VALUE_WIDTH-1:0] y
);

    // Wrap every result to the value width
    always_comb
    begin
        case (op)
            iee_pkg::OP_PLUS:  y = lhs + rhs;
            iee_pkg::OP_MINUS: y = lhs - rhs;
            default:           y = lhs * rhs;
        endcase
    end

endmodule

### hw/rtl/iee_checker.sv
// Port-level checks of the infix expression evaluator, bound to the top level.
`include "infix_expression_evaluator_defines.svh"

module iee_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  req_valid,
    input logic                                  req_ready,
    input logic [iee_pkg::KIND_W-1:0]            req_type,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic signed [iee_pkg::IO_VALUE_W-1:0] result_value,
    input logic [iee_pkg::STATUS_W-1:0]          status
);

    // A stalled result keeps its payload
    `IEE_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(result_value) && $stable(status))

    // A failed expression reports a zero value
    `IEE_ASSERT_IMPL(a_err_zero, clk, rst_n, rsp_valid && status != iee_pkg::ST_OK, result_value == '0)

    // An end mark always starts the closing sequence, so ready drops next
    `IEE_ASSERT_NEXT(a_end_busy, clk, rst_n, req_valid && req_ready && req_type == iee_pkg::KIND_END, !req_ready)

    // A new result only appears at the end of a busy sequence
    `IEE_ASSERT_IMPL(a_rsp_from_seq, clk, rst_n, $rose(rsp_valid), !$past(req_ready))

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_type     (req.req_type),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .status       (rsp.status)
);
